>>> src/sgss_pkg.sv
// Shared types, constants and the gain ladder for the stereo gain step sweeper.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package sgss_pkg;

  localparam int STEP_W      = 6;
  localparam int LVL_W       = 5;
  localparam int STEPLEN_W   = 22;
  localparam int RAMP_W      = 18;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 22;
  localparam int IN_LEVELS   = 9;
  localparam int ALL_LEVELS  = 21;
  localparam int ROM_FRAC    = 30;
  localparam int ROM_W       = 32;
  localparam int MAX_STEP    = 2 * ALL_LEVELS - 1;

  localparam logic [STEPLEN_W-1:0] STEP_LENGTH_RESET = STEPLEN_W'(96000);
  localparam logic [RAMP_W-1:0]    RAMP_LENGTH_RESET = RAMP_W'(4800);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_LENGTH  = 2'd0,
    REG_RAMP_LENGTH  = 2'd1,
    REG_SWEEP_MODE   = 2'd2
  } cfg_reg_t;

  // Ladder levels in Q2.30: attenuation rungs, mute, then over-cancel rungs.
  localparam logic [ROM_W-1:0] LEVEL_ROM [ALL_LEVELS] = '{
    32'd0,          32'd313590827,  32'd535596128,  32'd692763850,
    32'd804030072,  32'd882800537,  32'd938565737,  32'd978044493,
    32'd1073741824,
    32'd1137365028, 32'd1204758141, 32'd1276144550, 32'd1351761020,
    32'd1431857737, 32'd1516700633, 32'd1606570802, 32'd1701766107,
    32'd1802602103, 32'd1909412976, 32'd2022552574, 32'd2142396597
  };

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIVL_GO,
    ST_DIVL_WAIT,
    ST_DIVR_GO,
    ST_DIVR_WAIT,
    ST_GAIN,
    ST_MUL_L,
    ST_MUL_R,
    ST_WAIT
  } ctrl_state_t;

  typedef struct packed {
    logic in_capture;
    logic load_step;
    logic div_start;
    logic div_sel;
    logic slope_we;
    logic gain_upd;
    logic mul_l;
    logic mul_r;
    logic out_load;
  } sgss_cmd_t;

  typedef struct packed {
    logic step_pending;
    logic out_free;
    logic div_done;
  } sgss_stat_t;

  // Ladder entry rounded half up from Q2.30 to the datapath's fraction width.
  function automatic logic [ROM_W-1:0] rom_gain(input logic [STEP_W-1:0] lvl,
                                                input int sh);
    logic [LVL_W-1:0] idx;
    logic [ROM_W:0]   v;
    begin
      idx = (lvl >= STEP_W'(ALL_LEVELS)) ? LVL_W'(ALL_LEVELS - 1) : lvl[LVL_W-1:0];
      v   = {1'b0, LEVEL_ROM[idx]};
      if (sh > 0) begin
        v = (v + ((ROM_W+1)'(1) << (sh - 1))) >> sh;
      end
      return v[ROM_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

>>> src/sgss_div.sv
// Bit-serial signed divider for the ramp slopes, one quotient bit per cycle.
// Standalone; driven by the controller and the datapath.
`default_nettype none

module sgss_div #(
  parameter int QB = 24,
  parameter int DW = 18
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic signed [QB:0]   dividend,
  input  wire logic [DW-1:0]        divisor,
  output logic                      done,
  output logic signed [QB:0]        quot
);

  localparam int CW = $clog2(QB + 1);

  logic [QB-1:0] quo_r, quo_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] d_r;
  logic          neg_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          done_r, done_nxt;
  logic [QB:0]   mag;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  always_comb begin
    mag      = dividend[QB] ? (QB+1)'(-dividend) : dividend;
    trial    = {rem_r, quo_r[QB-1]};
    diff     = trial - {1'b0, d_r};
    ge       = trial >= {1'b0, d_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt = mag[QB-1:0];
      rem_nxt = '0;
      cnt_nxt = CW'(QB);
    end else if (cnt_r != '0) begin
      quo_nxt  = {quo_r[QB-2:0], ge};
      rem_nxt  = ge ? diff[DW-1:0] : trial[DW-1:0];
      cnt_nxt  = cnt_r - CW'(1);
      done_nxt = (cnt_r == CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      d_r   <= divisor;
      neg_r <= dividend[QB];
    end
  end

  assign done = done_r;
  assign quot = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});

endmodule

`default_nettype wire

>>> src/sgss_ctrl.sv
// Controller state machine that sequences step setup, gain ramp, mixing and output.
// Depends on sgss_pkg for the state enum and the command and status structs.
`default_nettype none

module sgss_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire sgss_pkg::sgss_stat_t stat,
  output sgss_pkg::sgss_cmd_t     cmd
);

  sgss_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sgss_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      sgss_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.in_capture = 1'b1;
          state_nxt = stat.step_pending ? sgss_pkg::ST_LOAD : sgss_pkg::ST_GAIN;
        end
      end
      sgss_pkg::ST_LOAD: begin
        cmd.load_step = 1'b1;
        state_nxt = sgss_pkg::ST_DIVL_GO;
      end
      sgss_pkg::ST_DIVL_GO: begin
        cmd.div_start = 1'b1;
        state_nxt = sgss_pkg::ST_DIVL_WAIT;
      end
      sgss_pkg::ST_DIVL_WAIT: begin
        if (stat.div_done) begin
          cmd.slope_we = 1'b1;
          state_nxt = sgss_pkg::ST_DIVR_GO;
        end
      end
      sgss_pkg::ST_DIVR_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = 1'b1;
        state_nxt = sgss_pkg::ST_DIVR_WAIT;
      end
      sgss_pkg::ST_DIVR_WAIT: begin
        cmd.div_sel = 1'b1;
        if (stat.div_done) begin
          cmd.slope_we = 1'b1;
          state_nxt = sgss_pkg::ST_GAIN;
        end
      end
      sgss_pkg::ST_GAIN: begin
        cmd.gain_upd = 1'b1;
        state_nxt = sgss_pkg::ST_MUL_L;
      end
      sgss_pkg::ST_MUL_L: begin
        cmd.mul_l = 1'b1;
        state_nxt = sgss_pkg::ST_MUL_R;
      end
      sgss_pkg::ST_MUL_R: begin
        cmd.mul_r = 1'b1;
        state_nxt = sgss_pkg::ST_WAIT;
      end
      sgss_pkg::ST_WAIT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt = sgss_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sgss_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> src/sgss_dp.sv
// Datapath: configuration, sweep position, gain ramp, shared multiplier and output register.
// Depends on sgss_pkg; takes commands from sgss_ctrl and slopes from sgss_div.
`default_nettype none

module sgss_dp #(
  parameter int SAMPLE_BITS    = 24,
  parameter int GAIN_FRAC_BITS = 22
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  cfg_we,
  input  wire logic [sgss_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [sgss_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  wire logic signed [SAMPLE_BITS-1:0]         in_left,
  input  wire logic signed [SAMPLE_BITS-1:0]         in_right,
  input  wire sgss_pkg::sgss_cmd_t                   cmd,
  input  wire logic                                  out_tready,
  output logic                                       step_pending,
  output logic                                       out_free,
  output logic signed [GAIN_FRAC_BITS+2:0]           div_dividend,
  output logic [sgss_pkg::RAMP_W-1:0]                div_divisor,
  input  wire logic signed [GAIN_FRAC_BITS+2:0]      div_quot,
  output logic                                       out_tvalid,
  output logic signed [SAMPLE_BITS-1:0]              mix_left,
  output logic signed [SAMPLE_BITS-1:0]              mix_right,
  output logic [sgss_pkg::STEP_W-1:0]                out_step
);

  localparam int GW  = GAIN_FRAC_BITS + 2;
  localparam int GS  = GAIN_FRAC_BITS + 3;
  localparam int SW  = SAMPLE_BITS + 1;
  localparam int PW  = SW + GS;
  localparam int SH  = sgss_pkg::ROM_FRAC - GAIN_FRAC_BITS;
  localparam int SLW = sgss_pkg::STEPLEN_W;
  localparam int RW  = sgss_pkg::RAMP_W;
  localparam int KW  = sgss_pkg::STEP_W;
  localparam int HW  = PW + 2 - SAMPLE_BITS;

  localparam logic signed [GS-1:0] ONE = GS'(1) <<< GAIN_FRAC_BITS;

  logic [SLW-1:0] step_len_r;
  logic [RW-1:0]  ramp_len_r;
  logic           inph_r;

  logic [KW-1:0]  idx_r;
  logic [SLW-1:0] cnt_r;
  logic           pend_r;

  logic signed [GS-1:0] gain_l_r, gain_r_r, slope_l_r, slope_r_r;
  logic [GW-1:0]        tgt_l_r, tgt_r_r;
  logic [RW-1:0]        ramp_rem_r;
  logic [RW-1:0]        r_r;

  logic signed [SW-1:0]  s_r;
  logic signed [PW-1:0]  prod_r;
  logic signed [SAMPLE_BITS-1:0] res_l_r;
  logic                  ovalid_r;
  logic signed [SAMPLE_BITS-1:0] oleft_r, oright_r;
  logic [KW-1:0]         ostep_r;

  logic [KW-1:0]  n_lvl, n_steps, back, lvl;
  logic           on_left;
  logic [GW-1:0]  tgt_g;
  logic [SLW-1:0] eff_step;
  logic [RW-1:0]  r0, r_eff;
  logic [SLW-1:0] st_m1;
  logic [SLW:0]   cnt_inc;
  logic [KW-1:0]  idx_inc;
  logic signed [GS-1:0] tgt_l_ext, tgt_r_ext, mgain, one_m;
  logic signed [PW-1:0] prod_nxt;
  logic signed [SAMPLE_BITS-1:0] sat_p;

  function automatic logic signed [SAMPLE_BITS-1:0] sat_round(
      input logic signed [PW-1:0] p);
    logic signed [PW:0] sum;
    logic signed [PW:0] sh;
    logic [HW-1:0]      hi;
    begin
      sum = PW'(p) + (PW+1)'(ONE);
      sh  = sum >>> (GAIN_FRAC_BITS + 1);
      hi  = sh[PW:SAMPLE_BITS-1];
      if ((&hi) || !(|hi)) begin
        return sh[SAMPLE_BITS-1:0];
      end else if (sh[PW]) begin
        return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
        return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end
    end
  endfunction

  always_comb begin
    n_lvl   = inph_r ? KW'(sgss_pkg::IN_LEVELS) : KW'(sgss_pkg::ALL_LEVELS);
    n_steps = inph_r ? KW'(2 * sgss_pkg::IN_LEVELS) : KW'(2 * sgss_pkg::ALL_LEVELS);
    on_left = idx_r < n_lvl;
    back    = idx_r - n_lvl;
    if (on_left) begin
      lvl = idx_r;
    end else if (back < n_lvl) begin
      lvl = n_lvl - KW'(1) - back;
    end else begin
      lvl = '0;
    end
    tgt_g = GW'(sgss_pkg::rom_gain(lvl, SH));

    eff_step = (step_len_r == '0) ? SLW'(1) : step_len_r;
    st_m1    = eff_step - SLW'(1);
    r0       = (ramp_len_r == '0) ? RW'(1) : ramp_len_r;
    r_eff    = ({{(SLW-RW){1'b0}}, r0} >= eff_step) ? st_m1[RW-1:0] : r0;
    if (r_eff == '0) begin
      r_eff = RW'(1);
    end

    cnt_inc = {1'b0, cnt_r} + (SLW+1)'(1);
    idx_inc = idx_r + KW'(1);

    tgt_l_ext = $signed({1'b0, tgt_l_r});
    tgt_r_ext = $signed({1'b0, tgt_r_r});
    div_dividend = cmd.div_sel ? (tgt_r_ext - gain_r_r) : (tgt_l_ext - gain_l_r);
    div_divisor  = r_r;

    mgain    = cmd.mul_r ? gain_r_r : gain_l_r;
    one_m    = ONE - mgain;
    prod_nxt = s_r * one_m;
    sat_p    = sat_round(prod_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_len_r <= sgss_pkg::STEP_LENGTH_RESET;
      ramp_len_r <= sgss_pkg::RAMP_LENGTH_RESET;
      inph_r     <= 1'b0;
      idx_r      <= '0;
      cnt_r      <= '0;
      pend_r     <= 1'b1;
      gain_l_r   <= '0;
      gain_r_r   <= '0;
      tgt_l_r    <= '0;
      tgt_r_r    <= '0;
      slope_l_r  <= '0;
      slope_r_r  <= '0;
      ramp_rem_r <= '0;
      ovalid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (sgss_pkg::cfg_reg_t'(cfg_index))
          sgss_pkg::REG_STEP_LENGTH: step_len_r <= cfg_wdata[SLW-1:0];
          sgss_pkg::REG_RAMP_LENGTH: ramp_len_r <= cfg_wdata[RW-1:0];
          sgss_pkg::REG_SWEEP_MODE: begin
            inph_r <= cfg_wdata[0];
            idx_r  <= '0;
            cnt_r  <= '0;
            pend_r <= 1'b1;
          end
          default: ;
        endcase
      end
      if (cmd.load_step) begin
        tgt_l_r    <= on_left ? tgt_g : '0;
        tgt_r_r    <= on_left ? '0 : tgt_g;
        r_r        <= r_eff;
        ramp_rem_r <= r_eff;
        pend_r     <= 1'b0;
      end
      if (cmd.slope_we) begin
        if (cmd.div_sel) begin
          slope_r_r <= div_quot;
        end else begin
          slope_l_r <= div_quot;
        end
      end
      if (cmd.gain_upd && (ramp_rem_r != '0)) begin
        ramp_rem_r <= ramp_rem_r - RW'(1);
        if (ramp_rem_r == RW'(1)) begin
          gain_l_r <= tgt_l_ext;
          gain_r_r <= tgt_r_ext;
        end else begin
          gain_l_r <= gain_l_r + slope_l_r;
          gain_r_r <= gain_r_r + slope_r_r;
        end
      end
      if (cmd.out_load) begin
        ovalid_r <= 1'b1;
        if (cnt_inc >= {1'b0, eff_step}) begin
          cnt_r  <= '0;
          idx_r  <= (idx_inc >= n_steps) ? '0 : idx_inc;
          pend_r <= 1'b1;
        end else begin
          cnt_r <= cnt_inc[SLW-1:0];
        end
      end else if (out_tready) begin
        ovalid_r <= 1'b0;
      end
    end
    if (cmd.in_capture) begin
      s_r <= SW'(in_left) + SW'(in_right);
    end
    if (cmd.mul_l || cmd.mul_r) begin
      prod_r <= prod_nxt;
    end
    if (cmd.mul_r) begin
      res_l_r <= sat_p;
    end
    if (cmd.out_load) begin
      oleft_r  <= res_l_r;
      oright_r <= sat_p;
      ostep_r  <= idx_r;
    end
  end

  assign step_pending = pend_r;
  assign out_free     = !ovalid_r || out_tready;
  assign out_tvalid   = ovalid_r;
  assign mix_left     = oleft_r;
  assign mix_right    = oright_r;
  assign out_step     = ostep_r;

endmodule

`default_nettype wire

>>> src/stereo_gain_step_sweeper_top.sv
// Top level of the stereo gain step sweeper: stream ports, configuration port, wiring.
// Instantiates sgss_ctrl, sgss_dp and sgss_div; depends on sgss_pkg.
//
//   Channel | Direction | Word contents
//   in_     | slave     | left_sample, right_sample
//   out_    | master    | left_out, right_out, step_number
//   cfg_    | write     | step_length, ramp_length, sweep mode by index
//
// A word passes through ST_GAIN, ST_MUL_L and ST_MUL_R to ST_WAIT, which loads the output
// register once it is free; the next word can be accepted in the cycle after that load.
// The first word of each sweep step also passes through ST_LOAD and the two
// bit-serial slope divisions in sgss_div, one quotient bit per cycle, before ST_GAIN.
// Reset is synchronous and active low; no clearing pass is needed.
// The next word is accepted while a finished word waits in the output register.
`default_nettype none

module stereo_gain_step_sweeper_top #(
  parameter int SAMPLE_BITS    = 24,
  parameter int GAIN_FRAC_BITS = 22
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // left_sample, right_sample
  input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0]  in_tdata,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // left_out, right_out, step_number
  output logic [((2*SAMPLE_BITS+sgss_pkg::STEP_W+7)/8)*8-1:0] out_tdata,
  input  wire logic                                cfg_we,
  input  wire logic [sgss_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [sgss_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int OUT_W = ((2*SAMPLE_BITS+sgss_pkg::STEP_W+7)/8)*8;
  localparam int GS    = GAIN_FRAC_BITS + 3;

  sgss_pkg::sgss_cmd_t  cmd;
  sgss_pkg::sgss_stat_t stat;

  logic                            step_pending;
  logic                            out_free;
  logic                            div_done;
  logic signed [GS-1:0]            div_dividend;
  logic signed [GS-1:0]            div_quot;
  logic [sgss_pkg::RAMP_W-1:0]     div_divisor;
  logic signed [SAMPLE_BITS-1:0]   mix_left, mix_right;
  logic [sgss_pkg::STEP_W-1:0]     out_step;

  assign stat.step_pending = step_pending;
  assign stat.out_free     = out_free;
  assign stat.div_done     = div_done;

  sgss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sgss_dp #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_left      (in_tdata[SAMPLE_BITS-1:0]),
    .in_right     (in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .cmd          (cmd),
    .out_tready   (out_tready),
    .step_pending (step_pending),
    .out_free     (out_free),
    .div_dividend (div_dividend),
    .div_divisor  (div_divisor),
    .div_quot     (div_quot),
    .out_tvalid   (out_tvalid),
    .mix_left     (mix_left),
    .mix_right    (mix_right),
    .out_step     (out_step)
  );

  sgss_div #(
    .QB (GS - 1),
    .DW (sgss_pkg::RAMP_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot)
  );

  assign out_tdata = OUT_W'({out_step, mix_right, mix_left});

endmodule

`default_nettype wire

>>> src/sgss_checker.sv
// Port-level checker for the stereo gain step sweeper and its bind to the top level.
// Depends on sgss_pkg and on the port list of stereo_gain_step_sweeper_top.
`default_nettype none

module sgss_checker #(
  parameter int SAMPLE_BITS    = 24
) (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                in_tvalid,
  input wire logic                                in_tready,
  input wire logic                                out_tvalid,
  input wire logic                                out_tready,
  input wire logic [((2*SAMPLE_BITS+sgss_pkg::STEP_W+7)/8)*8-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result word changed while stalled");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[2*SAMPLE_BITS +: sgss_pkg::STEP_W]
                    <= sgss_pkg::STEP_W'(sgss_pkg::MAX_STEP)))
    else $error("step number beyond the sweep");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while a word is in work");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind stereo_gain_step_sweeper_top sgss_checker #(
  .SAMPLE_BITS    (SAMPLE_BITS)
) u_sgss_checker (.*);

`default_nettype wire
